// ===== hw/rtl/sbcf_pkg.sv =====
// Shared types and constants of the breathing colour fade block.
`default_nettype none

package sbcf_pkg;

    localparam int DELTA_W    = 12;
    localparam int TIME_W     = 24;
    localparam int COLOR_W    = 32;
    localparam int RATE_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int CHANNELS   = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        REG_ORIGINAL = 3'd0,
        REG_BREATH   = 3'd1,
        REG_RATE     = 3'd2,
        REG_DURATION = 3'd3,
        REG_LOOP     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [COLOR_W-1:0] original_color;
        logic [COLOR_W-1:0] breath_color;
        logic [RATE_W-1:0]  phase_rate;
        logic [TIME_W-1:0]  duration_units;
        logic               loop_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sine_breathing_color_fade_core.sv =====
// Top level of the breathing colour fade: register port, front part, queue and back part.
// A tick passes the tick queue and factor register to the result queue, where empty falls.
// One tick is taken every cycle unless full is high; the phase and time update sets this rate.
// Stalls on the result side fill a four-entry result queue and then a four-entry tick queue.
// Reset is asynchronous and active low; it clears state and queues and loads register defaults.
`default_nettype none

module sine_breathing_color_fade_core #(
    parameter int PHASE_BITS   = 16,
    parameter int SINE_ENTRIES = 256,
    parameter int FACTOR_BITS  = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [sbcf_pkg::DELTA_W-1:0]       delta_units,
    output logic                               empty,
    input  logic                               pop,
    output logic [sbcf_pkg::CHAN_W-1:0]        red,
    output logic [sbcf_pkg::CHAN_W-1:0]        green,
    output logic [sbcf_pkg::CHAN_W-1:0]        blue,
    output logic [sbcf_pkg::CHAN_W-1:0]        alpha,
    output logic                               finished
);

    import sbcf_pkg::*;

    localparam int IDX_W = $clog2(SINE_ENTRIES);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    reg_index_t       reg_sel;
    logic             wr_en;
    logic             q_push;
    logic [IDX_W:0]   q_data;
    logic             q_full;
    logic             mid_empty;
    logic             mid_pop;
    logic [IDX_W:0]   mid_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] mid_count;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_ORIGINAL: cfg_next.original_color = pwdata;
                REG_BREATH:   cfg_next.breath_color   = pwdata;
                REG_RATE:     cfg_next.phase_rate     = pwdata[RATE_W-1:0];
                REG_DURATION: cfg_next.duration_units = pwdata[TIME_W-1:0];
                REG_LOOP:     cfg_next.loop_enable    = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ORIGINAL: prdata = cfg_reg.original_color;
            REG_BREATH:   prdata = cfg_reg.breath_color;
            REG_RATE:     prdata = 32'(cfg_reg.phase_rate);
            REG_DURATION: prdata = 32'(cfg_reg.duration_units);
            REG_LOOP:     prdata = 32'(cfg_reg.loop_enable);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.original_color <= '0;
            cfg_reg.breath_color   <= '0;
            cfg_reg.phase_rate     <= RATE_W'(256);
            cfg_reg.duration_units <= TIME_MAX;
            cfg_reg.loop_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbcf_front #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .delta_units (delta_units),
        .full        (full),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    sbcf_queue #(
        .WIDTH (IDX_W + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_data),
        .rd_en   (mid_pop),
        .rd_data (mid_data),
        .full    (q_full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    sbcf_back #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .FACTOR_BITS  (FACTOR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_data  (mid_data),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .finished  (finished)
    );

`ifndef SYNTHESIS
    a_mid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mid_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("Tick queue count exceeds its depth.");

    a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        full == (mid_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
        else $error("Full flag disagrees with the tick queue fill level.");

    a_pop_when_empty_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        mid_empty |-> (mid_count == '0))
        else $error("Tick queue reports empty while holding entries.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sbcf_queue.sv =====
// Small first-in first-out queue built from flip-flops.
`default_nettype none

module sbcf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sbcf_front.sv =====
// Front part: takes ticks, advances phase and elapsed time, and queues the table index.
`default_nettype none

module sbcf_front #(
    parameter int PHASE_BITS   = 16,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbcf_pkg::cfg_t                        cfg,
    input  logic                                  push,
    input  logic [sbcf_pkg::DELTA_W-1:0]          delta_units,
    output logic                                  full,
    input  logic                                  q_full,
    output logic                                  q_push,
    output logic [$clog2(SINE_ENTRIES):0]         q_data
);

    import sbcf_pkg::*;

    localparam int IDX_W  = $clog2(SINE_ENTRIES);
    localparam int PROD_W = DELTA_W + RATE_W;
    localparam int SUM_W  = ((PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W) + 1;
    localparam int EXT_W  = PHASE_BITS + IDX_W;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [TIME_W-1:0]     used_time_reg;
    logic [TIME_W-1:0]     used_time_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  accept;
    logic [PROD_W-1:0]     advance;
    logic [SUM_W-1:0]      phase_sum;
    logic [TIME_W:0]       time_sum;
    logic [EXT_W-1:0]      scaled;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        advance        = PROD_W'(delta_units) * PROD_W'(cfg.phase_rate);
        phase_sum      = SUM_W'(phase_reg) + SUM_W'(advance);
        time_sum       = (TIME_W + 1)'(used_time_reg) + (TIME_W + 1)'(delta_units);
        phase_next     = phase_reg;
        used_time_next = used_time_reg;
        done_next      = done_reg;
        if (!done_reg)
        begin
            phase_next     = phase_sum[PHASE_BITS-1:0];
            used_time_next = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
            done_next      = !cfg.loop_enable && (used_time_next >= cfg.duration_units);
        end
        scaled = {phase_next, IDX_W'(0)} >> PHASE_BITS;
        q_push = accept;
        q_data = {done_next, scaled[IDX_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            used_time_reg <= '0;
            done_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            used_time_reg <= used_time_next;
            done_reg      <= done_next;
        end
    end

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("Finished flag was cleared without reset.");

    a_frozen_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> ($stable(phase_reg) && $stable(used_time_reg)))
        else $error("State moved after the effect had finished.");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("Tick queued while the queue was full.");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sbcf_back.sv =====
// Back part: sine table lookup, colour blend and the result queue.
`default_nettype none

module sbcf_back #(
    parameter int SINE_ENTRIES = 256,
    parameter int FACTOR_BITS  = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbcf_pkg::cfg_t                        cfg,
    input  logic                                  mid_empty,
    input  logic [$clog2(SINE_ENTRIES):0]         mid_data,
    output logic                                  mid_pop,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [sbcf_pkg::CHAN_W-1:0]           red,
    output logic [sbcf_pkg::CHAN_W-1:0]           green,
    output logic [sbcf_pkg::CHAN_W-1:0]           blue,
    output logic [sbcf_pkg::CHAN_W-1:0]           alpha,
    output logic                                  finished
);

    import sbcf_pkg::*;

    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int F_W     = FACTOR_BITS + 1;
    localparam int PROD_W  = CHAN_W + 1 + F_W + 1;
    localparam int OUT_W   = CHANNELS * CHAN_W + 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

    typedef logic [F_W-1:0] rom_t [SINE_ENTRIES];

    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = x;
        pos  = x;
        neg  = '0;
        term = sq_step(term, x) / 64'd6;
        neg  = neg + term;
        term = sq_step(term, x) / 64'd20;
        pos  = pos + term;
        term = sq_step(term, x) / 64'd42;
        neg  = neg + term;
        term = sq_step(term, x) / 64'd72;
        pos  = pos + term;
        term = sq_step(term, x) / 64'd110;
        neg  = neg + term;
        term = sq_step(term, x) / 64'd156;
        pos  = pos + term;
        term = sq_step(term, x) / 64'd210;
        neg  = neg + term;
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] ii;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] u;
        logic [63:0] v;
        logic        negative;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            ii       = 64'(i);
            negative = (2 * ii) > 64'(SINE_ENTRIES);
            j        = negative ? 64'(SINE_ENTRIES) - ii : ii;
            x        = (j * Q30_TWO_PI) / 64'(SINE_ENTRIES);
            if (x > Q30_HALF_PI)
            begin
                x = (x > Q30_PI) ? 64'd0 : Q30_PI - x;
            end
            s = sin_q30(x);
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            u      = negative ? Q30_ONE - s : Q30_ONE + s;
            v      = ((u << FACTOR_BITS) + Q30_ONE) >> 31;
            rom[i] = v[F_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic                 va_reg;
    logic [F_W-1:0]       factor_reg;
    logic                 fin_reg;
    logic [CNT_W-1:0]     out_count;
    logic                 out_full;
    logic [OUT_W-1:0]     out_data;
    logic [OUT_W-1:0]     out_word;
    logic [CNT_W:0]       in_flight;

    assign in_flight = (CNT_W + 1)'(out_count) + (CNT_W + 1)'(va_reg);
    assign mid_pop   = !mid_empty && (in_flight < (CNT_W + 1)'(QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= mid_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            factor_reg <= SINE_ROM[mid_data[IDX_W-1:0]];
            fin_reg    <= mid_data[IDX_W];
        end
    end

    always_comb
    begin
        logic [CHAN_W-1:0]        o;
        logic [CHAN_W-1:0]        b;
        logic signed [PROD_W-1:0] diff;
        logic signed [PROD_W-1:0] fac;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] sum;
        out_data = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            o    = cfg.original_color[k*CHAN_W +: CHAN_W];
            b    = cfg.breath_color[k*CHAN_W +: CHAN_W];
            diff = PROD_W'($signed({1'b0, b})) - PROD_W'($signed({1'b0, o}));
            fac  = PROD_W'($signed({1'b0, factor_reg}));
            prod = diff * fac;
            sum  = PROD_W'($signed({1'b0, o})) + (prod >>> FACTOR_BITS);
            out_data[k*CHAN_W +: CHAN_W] = fin_reg ? o : sum[CHAN_W-1:0];
        end
        out_data[OUT_W-1] = fin_reg;
    end

    sbcf_queue #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (va_reg),
        .wr_data (out_data),
        .rd_en   (pop),
        .rd_data (out_word),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign red      = out_word[0*CHAN_W +: CHAN_W];
    assign green    = out_word[1*CHAN_W +: CHAN_W];
    assign blue     = out_word[2*CHAN_W +: CHAN_W];
    assign alpha    = out_word[3*CHAN_W +: CHAN_W];
    assign finished = out_word[OUT_W-1];

`ifndef SYNTHESIS
    a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> !out_full)
        else $error("A result reached the full result queue and would be lost.");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= (CNT_W + 1)'(QUEUE_DEPTH))
        else $error("More results in flight than the result queue can hold.");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("Back part took an entry from an empty queue.");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_sine_breathing_color_fade_core.sv =====
// Self-checking testbench of the breathing colour fade core with its own predictor.
module tb_sine_breathing_color_fade_core;
    import sbcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PRESSURE_PHASE = 3;
    localparam int PHASE_ITEMS    = 100;
    localparam int LONG_ITEMS     = 60;
    localparam int TAIL_ITEMS     = 40;
    localparam int LUT_SIZE       = 256;
    localparam int LEVEL_BITS     = 10;

    localparam logic [4:0] SPARE_ADDR_LO = 5'd20;
    localparam logic [4:0] SPARE_ADDR_HI = 5'd28;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              finished;
    } pixel_t;

    typedef struct {
        cfg_t                 cfg;
        logic [DELTA_W-1:0]   delta;
        bit                   typed;
        bit                   poke_spare;
        pixel_t               want;
    } tick_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               push;
    logic               full;
    logic [DELTA_W-1:0] delta_units;
    logic               empty;
    logic               pop = 1'b0;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic               finished;

    logic [LEVEL_BITS:0] sine_lut [LUT_SIZE];
    cfg_t                fade_cfg;
    logic [15:0]         fade_phase;
    logic [TIME_W-1:0]   fade_time;
    logic                fade_done;
    pixel_t              pixel_q [$];
    tick_row_t           directed_rows [$];

    int  mismatches;
    int  ticks_sent;
    int  pixels_checked;
    int  full_cycles;
    int  settings_applied;
    int  quiet_cycles;
    int  hold_requests;
    int  holds_done;
    int  hold_left;
    int  idle_left;
    bit  sender_idles;
    bit  receiver_idles;

    sine_breathing_color_fade_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .delta_units (delta_units),
        .empty       (empty),
        .pop         (pop),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .finished    (finished)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string label, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s is %h, expected %h",
                                      pixels_checked, label, got, want));
        end
    endtask

    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] n;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (n = 64'd1; n <= 64'd7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((64'd2 * n) * (64'd2 * n + 64'd1));
            if (n[0])
                neg += term;
            else
                pos += term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    task automatic fill_sine_lut();
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] u;
        logic [63:0] v;
        bit          negative;
        int          i;
        for (i = 0; i < LUT_SIZE; i++)
        begin
            negative = (2 * i > LUT_SIZE);
            j = negative ? 64'(LUT_SIZE - i) : 64'(i);
            x = (j * Q30_TWO_PI) / LUT_SIZE;
            if (x > Q30_HALF_PI)
                x = (x > Q30_PI) ? 64'd0 : Q30_PI - x;
            s = sine_q30(x);
            if (s > Q30_ONE)
                s = Q30_ONE;
            u = negative ? Q30_ONE - s : Q30_ONE + s;
            v = ((u << LEVEL_BITS) + Q30_ONE) >> 31;
            sine_lut[i] = v[LEVEL_BITS:0];
        end
    endtask

    function automatic logic [7:0] blend_channel(input logic [7:0] o, input logic [7:0] b,
                                                 input logic [LEVEL_BITS:0] f);
        int diff;
        int step;
        int mix;
        diff = int'(b) - int'(o);
        step = (diff * int'(f)) >>> LEVEL_BITS;
        mix  = int'(o) + step;
        return mix[7:0];
    endfunction

    function automatic pixel_t advance_fade(input logic [DELTA_W-1:0] d);
        logic [TIME_W:0]     t;
        logic [31:0]         adv;
        logic [LEVEL_BITS:0] f;
        pixel_t              p;
        if (!fade_done)
        begin
            t = fade_time + d;
            fade_time = (t > {1'b0, TIME_MAX}) ? TIME_MAX : t[TIME_W-1:0];
            adv = d * fade_cfg.phase_rate;
            fade_phase = fade_phase + adv[15:0];
            if (!fade_cfg.loop_enable && fade_time >= fade_cfg.duration_units)
                fade_done = 1'b1;
        end
        if (fade_done)
        begin
            p.red      = fade_cfg.original_color[7:0];
            p.green    = fade_cfg.original_color[15:8];
            p.blue     = fade_cfg.original_color[23:16];
            p.alpha    = fade_cfg.original_color[31:24];
            p.finished = 1'b1;
        end
        else
        begin
            f = sine_lut[fade_phase[15:8]];
            p.red      = blend_channel(fade_cfg.original_color[7:0],
                                       fade_cfg.breath_color[7:0], f);
            p.green    = blend_channel(fade_cfg.original_color[15:8],
                                       fade_cfg.breath_color[15:8], f);
            p.blue     = blend_channel(fade_cfg.original_color[23:16],
                                       fade_cfg.breath_color[23:16], f);
            p.alpha    = blend_channel(fade_cfg.original_color[31:24],
                                       fade_cfg.breath_color[31:24], f);
            p.finished = 1'b0;
        end
        return p;
    endfunction

    function automatic cfg_t make_cfg(input logic [31:0] orig, input logic [31:0] breath,
                                      input logic [15:0] rate, input logic [TIME_W-1:0] dur,
                                      input logic loop);
        cfg_t c;
        c.original_color = orig;
        c.breath_color   = breath;
        c.phase_rate     = rate;
        c.duration_units = dur;
        c.loop_enable    = loop;
        return c;
    endfunction

    function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a,
                                          input logic fin);
        pixel_t p;
        p.red      = r;
        p.green    = g;
        p.blue     = b;
        p.alpha    = a;
        p.finished = fin;
        return p;
    endfunction

    task automatic add_row(input cfg_t c, input logic [DELTA_W-1:0] d, input bit typed,
                           input bit poke, input pixel_t want);
        tick_row_t r;
        r.cfg        = c;
        r.delta      = d;
        r.typed      = typed;
        r.poke_spare = poke;
        r.want       = want;
        directed_rows.push_back(r);
    endtask

    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [4:0] addr, output logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_register(input reg_index_t idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] back;
        case (idx)
            REG_ORIGINAL:
            begin
                mask = 32'hFFFF_FFFF;
                fade_cfg.original_color = val;
            end
            REG_BREATH:
            begin
                mask = 32'hFFFF_FFFF;
                fade_cfg.breath_color = val;
            end
            REG_RATE:
            begin
                mask = 32'h0000_FFFF;
                fade_cfg.phase_rate = val[RATE_W-1:0];
            end
            REG_DURATION:
            begin
                mask = 32'h00FF_FFFF;
                fade_cfg.duration_units = val[TIME_W-1:0];
            end
            default:
            begin
                mask = 32'h0000_0001;
                fade_cfg.loop_enable = val[0];
            end
        endcase
        apb_write({idx, 2'b00}, val);
        apb_read({idx, 2'b00}, back);
        if (back !== (val & mask))
        begin
            report_mismatch($sformatf("register %s reads %h, expected %h",
                                      idx.name(), back, val & mask));
        end
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (pixel_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_setting(input cfg_t c);
        logic [31:0] junk;
        junk = $urandom;
        drain_results();
        set_register(REG_ORIGINAL, c.original_color);
        set_register(REG_BREATH, c.breath_color);
        set_register(REG_RATE, {junk[15:0], c.phase_rate});
        set_register(REG_DURATION, {junk[23:16], c.duration_units});
        set_register(REG_LOOP, {junk[31:1], c.loop_enable});
        settings_applied++;
    endtask

    task automatic send_tick(input logic [DELTA_W-1:0] d, input bit typed, input pixel_t want);
        pixel_t p;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        push        = 1'b1;
        delta_units = d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        p = advance_fade(d);
        pixel_q.push_back(typed ? want : p);
        ticks_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_color();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t random_setting(input logic loop);
        cfg_t c;
        c.original_color = random_color();
        c.breath_color   = random_color();
        case ($urandom_range(0, 5))
            0:       c.phase_rate = 16'h0000;
            1:       c.phase_rate = 16'hFFFF;
            2:       c.phase_rate = 16'h0001;
            default: c.phase_rate = 16'($urandom_range(0, 65535));
        endcase
        c.loop_enable = loop;
        if (!loop)
            c.duration_units = TIME_W'($urandom_range(24'hF00000, 24'hFFFFFF));
        else
        begin
            case ($urandom_range(0, 3))
                0:       c.duration_units = '0;
                1:       c.duration_units = TIME_MAX;
                default: c.duration_units = TIME_W'($urandom_range(0, 24'hFFFFFF));
            endcase
        end
        return c;
    endfunction

    function automatic logic [DELTA_W-1:0] random_delta();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DELTA_W'($urandom_range(1, 15));
            default: return DELTA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (holds_done != hold_requests)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            pop = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop = 1'b0;
        end
        else if (idle_left > 0)
        begin
            idle_left--;
            pop = 1'b0;
        end
        else if (receiver_idles && $urandom_range(0, 5) == 0)
        begin
            idle_left = $urandom_range(1, 5) - 1;
            pop = 1'b0;
        end
        else
            pop = 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && push && full)
            full_cycles++;
        if (rst_n && pop && !empty)
        begin
            if (pixel_q.size() == 0)
                report_mismatch("result transfer with no expectation waiting");
            else
            begin
                want = pixel_q.pop_front();
                check_field("red", red, want.red);
                check_field("green", green, want.green);
                check_field("blue", blue, want.blue);
                check_field("alpha", alpha, want.alpha);
                check_field("finished", {7'd0, finished}, {7'd0, want.finished});
                pixels_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles with %0d results outstanding.",
                         quiet_cycles, pixel_q.size());
                $display("sine_breathing_color_fade_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t      c;
        cfg_t      reset_cfg;
        cfg_t      cfg_a;
        cfg_t      cfg_b;
        cfg_t      cfg_c;
        cfg_t      cfg_d;
        cfg_t      cfg_e;
        tick_row_t r;
        pixel_t    none;
        pixel_t    black;
        int        ph;
        int        k;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        push        = 1'b0;
        delta_units = '0;
        none        = '0;
        black       = make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        fill_sine_lut();
        reset_cfg  = make_cfg(32'h0, 32'h0, 16'd256, TIME_MAX, 1'b0);
        fade_cfg   = reset_cfg;
        fade_phase = '0;
        fade_time  = '0;
        fade_done  = 1'b0;

        cfg_a = make_cfg(32'h0000_0000, 32'hFFFF_FFFF, 16'd256, TIME_MAX, 1'b0);
        cfg_b = make_cfg(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, TIME_MAX, 1'b0);
        cfg_c = make_cfg(32'h1234_5678, 32'h1234_5678, 16'd4321, TIME_MAX, 1'b0);
        cfg_d = make_cfg(32'h80FF_0010, 32'h017F_20EE, 16'h0000, 24'h000000, 1'b1);
        cfg_e = make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, TIME_MAX, 1'b1);

        add_row(reset_cfg, 12'd0, 1, 0, black);
        add_row(reset_cfg, 12'd4095, 1, 0, black);
        add_row(reset_cfg, 12'd1, 1, 0, black);
        add_row(cfg_a, 12'd0, 0, 0, none);
        add_row(cfg_a, 12'd64, 0, 1, none);
        add_row(cfg_a, 12'd64, 0, 0, none);
        add_row(cfg_a, 12'd64, 0, 0, none);
        add_row(cfg_a, 12'd64, 0, 0, none);
        add_row(cfg_a, 12'd4095, 0, 0, none);
        add_row(cfg_b, 12'd1, 0, 0, none);
        add_row(cfg_b, 12'd1, 0, 0, none);
        add_row(cfg_b, 12'd4095, 0, 0, none);
        add_row(cfg_b, 12'd2048, 0, 0, none);
        add_row(cfg_c, 12'd4095, 1, 0, make_pixel(8'h78, 8'h56, 8'h34, 8'h12, 1'b0));
        add_row(cfg_c, 12'd3, 1, 0, make_pixel(8'h78, 8'h56, 8'h34, 8'h12, 1'b0));
        add_row(cfg_d, 12'd0, 0, 0, none);
        add_row(cfg_d, 12'd4095, 0, 0, none);
        add_row(cfg_d, 12'd7, 0, 0, none);
        add_row(cfg_e, 12'd4095, 1, 0, make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        add_row(cfg_e, 12'd0, 1, 0, make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.cfg != fade_cfg)
                apply_setting(r.cfg);
            if (r.poke_spare)
            begin
                // Writes to addresses past the last register must leave every setting alone.
                drain_results();
                apb_write(SPARE_ADDR_LO, $urandom);
                apb_write(SPARE_ADDR_HI, $urandom);
            end
            send_tick(r.delta, r.typed, r.want);
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            c = random_setting(ph[0]);
            apply_setting(c);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            if (ph == PRESSURE_PHASE)
            begin
                sender_idles = 1'b0;
                hold_requests++;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
                send_tick(random_delta(), 0, none);
        end

        // Long ticks with looping on.
        c = random_setting(1'b1);
        apply_setting(c);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (k = 0; k < LONG_ITEMS; k++)
            send_tick(DELTA_W'($urandom_range(3800, 4095)), 0, none);

        c = random_setting(1'b0);
        c.duration_units = TIME_MAX;
        apply_setting(c);
        for (k = 0; k < TAIL_ITEMS; k++)
            send_tick(random_delta(), 0, none);

        // A zero duration without looping finishes on the first tick.
        c = random_setting(1'b0);
        c.duration_units = '0;
        apply_setting(c);
        for (k = 0; k < TAIL_ITEMS; k++)
            send_tick(random_delta(), 0, none);

        // Once finished, turning looping on leaves the finish in place.
        c = random_setting(1'b1);
        apply_setting(c);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (k = 0; k < TAIL_ITEMS; k++)
            send_tick(random_delta(), 0, none);

        push = 1'b0;
        while (pixel_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Run covered %0d ticks under %0d register settings; %0d results compared.",
                 ticks_sent, settings_applied, pixels_checked);
        $display("Input stalled for %0d cycles; the finish held once looping came on.",
                 full_cycles);
        if (mismatches == 0)
            $display("sine_breathing_color_fade_core regression: pass");
        else
            $display("sine_breathing_color_fade_core regression: fail");
        $finish;
    end

endmodule
